// File: rtl/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types and constants of the key sequence matcher.
// ----------------------------------------------------------------------------
package ksm_pkg;

  localparam int NUM_PATTERN_REGS = 4;
  localparam int NUM_OUT_ARGS     = 4;
  localparam int POS_W            = 4;
  localparam int LEN_W            = 4;
  localparam int KEY_W            = 8;
  localparam int PAT_W            = 64;

  localparam logic [KEY_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [KEY_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [KEY_W-1:0] CH_NINE    = 8'h39;

  // outcome of checking one key against one sequence
  typedef struct packed {
    logic [POS_W-1:0] pos_next;
    logic             capture;
    logic [3:0]       slot;
    logic             literal_hit;
    logic             done;
  } step_res_t;

endpackage

// File: rtl/ksm_step.sv
// ----------------------------------------------------------------------------
// ksm_step
// Shared step unit: checks one key against one pattern at its position.
// ----------------------------------------------------------------------------
module ksm_step import ksm_pkg::*; (
  input  logic [KEY_W-1:0] key,
  input  logic [PAT_W-1:0] pattern,
  input  logic [LEN_W-1:0] len,
  input  logic [POS_W-1:0] pos,
  output step_res_t        res
);

  logic [POS_W-1:0] pos_eff;
  logic [2:0]       pos_lo;
  logic [2:0]       pos_hi;
  logic [KEY_W-1:0] b;
  logic [KEY_W-1:0] d;
  logic             has_next;
  logic             is_digit;
  logic [POS_W:0]   pos_sum;

  always_comb begin
    // a stale position past a shortened length starts over
    pos_eff  = (pos >= len) ? '0 : pos;
    pos_lo   = pos_eff[2:0];
    pos_hi   = pos_lo + 3'd1;
    b        = pattern[8*pos_lo +: 8];
    d        = pattern[8*pos_hi +: 8];
    has_next = ({1'b0, pos_eff} + 5'd1) < {1'b0, len};
    is_digit = (d >= CH_ZERO) && (d <= CH_NINE);

    res.capture     = 1'b0;
    res.literal_hit = 1'b0;
    res.slot        = 4'(d - CH_ZERO);
    pos_sum         = '0;
    if (b == CH_PERCENT && has_next && is_digit) begin
      res.capture = 1'b1;
      pos_sum     = {1'b0, pos_eff} + 5'd2;
    end else if (key == b) begin
      res.literal_hit = 1'b1;
      pos_sum         = {1'b0, pos_eff} + 5'd1;
    end
    res.pos_next = pos_sum[POS_W-1:0];
    res.done     = pos_sum >= {1'b0, len};
  end

endmodule

// File: rtl/key_sequence_matcher_with_capture.sv
// ----------------------------------------------------------------------------
// key_sequence_matcher_with_capture
// Matches key-down items against stored patterns with argument capture.
// ----------------------------------------------------------------------------
// order: the stored sequences are checked one at a time in order, up to the first
//   completion; a completion then reads min(MAX_ARGS,4) slots of the argument
//   memory before the result goes into the output register; a non-key-down item
//   goes straight to the output register. The single shared step unit takes no
//   new item before the last is out; a result held in the output register stalls
// reset: positions, argument valid bits, config registers and handshake clear
module key_sequence_matcher_with_capture import ksm_pkg::*; #(
  parameter int NUM_SEQUENCES     = 4,
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_ARGS          = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_code
  input  logic        s_tuser,   // key_down
  output logic        m_tvalid,
  input  logic        m_tready,
  // consumed, completed, which_sequence[1:0], arg_one, arg_two, arg_three,
  // arg_four, zero pad
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NUM_ACTIVE = (NUM_SEQUENCES < NUM_PATTERN_REGS) ? NUM_SEQUENCES
                                                                  : NUM_PATTERN_REGS;
  localparam int SEQ_W  = (NUM_ACTIVE > 1) ? $clog2(NUM_ACTIVE) : 1;
  localparam int DEPTH  = NUM_ACTIVE * MAX_ARGS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int N_OUT  = (MAX_ARGS < NUM_OUT_ARGS) ? MAX_ARGS : NUM_OUT_ARGS;
  localparam int RD_W   = $clog2(N_OUT + 1);

  localparam logic [2:0] REG_LENGTHS = 3'd4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [PAT_W-1:0]  pattern [NUM_PATTERN_REGS];
  logic [15:0]       lengths;
  logic [POS_W-1:0]  match_pos [NUM_ACTIVE];

  logic [1:0]        state;
  logic [SEQ_W-1:0]  seq;
  logic [RD_W-1:0]   rd_cnt;
  logic [KEY_W-1:0]  key;

  logic              res_consumed;
  logic              res_completed;
  logic [1:0]        res_which;
  logic [7:0]        res_arg [NUM_OUT_ARGS];

  logic [KEY_W-1:0]  arg_mem [DEPTH];
  logic [DEPTH-1:0]  arg_valid;
  logic [7:0]        rd_data;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  logic [1:0]        seq_idx;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len;
  logic              seq_on;
  logic              last_seq;
  step_res_t         step;

  assign s_tready = (state == ST_IDLE);
  assign seq_idx  = 2'(seq);
  assign len_raw  = lengths[4*seq_idx +: 4];
  assign len      = (int'(len_raw) > MAX_PATTERN_BYTES) ? LEN_W'(MAX_PATTERN_BYTES)
                                                        : len_raw;
  assign seq_on   = (len != '0);
  assign last_seq = (seq == SEQ_W'(NUM_ACTIVE - 1));

  ksm_step u_step (
    .key     (key),
    .pattern (pattern[seq_idx]),
    .len     (len),
    .pos     (match_pos[seq]),
    .res     (step)
  );

  always_comb begin
    wr_en   = (state == ST_STEP) && seq_on && step.capture &&
              (step.slot != 4'd0) && (int'(step.slot) <= MAX_ARGS);
    wr_addr = ADDR_W'(int'(seq) * MAX_ARGS + int'(step.slot) - 1);
    rd_addr = ADDR_W'(int'(seq) * MAX_ARGS + int'(rd_cnt));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PATTERN_REGS; i++) pattern[i] <= '0;
      lengths <= '0;
    end else if (cfg_we) begin
      if (cfg_index < REG_LENGTHS) pattern[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == REG_LENGTHS) lengths <= cfg_data[15:0];
    end
  end

  // argument memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (wr_en) arg_mem[wr_addr] <= key;
    rd_data <= arg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) arg_valid[wr_addr] <= 1'b1;
      rd_ok <= arg_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      seq      <= '0;
      rd_cnt   <= '0;
      for (int i = 0; i < NUM_ACTIVE; i++) match_pos[i] <= '0;
    end else begin
      // the output state reloads the register itself
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            key           <= s_tdata;
            seq           <= '0;
            res_consumed  <= 1'b0;
            res_completed <= 1'b0;
            res_which     <= '0;
            for (int i = 0; i < NUM_OUT_ARGS; i++) res_arg[i] <= '0;
            state <= s_tuser ? ST_STEP : ST_OUT;
          end
        end
        ST_STEP: begin
          if (seq_on) begin
            match_pos[seq] <= step.done ? '0 : step.pos_next;
            if (step.done || step.capture) res_consumed <= 1'b1;
            else if (step.literal_hit) res_consumed <= 1'b0;
          end
          if (seq_on && step.done) begin
            res_completed <= 1'b1;
            res_which     <= seq_idx;
            rd_cnt        <= '0;
            state         <= ST_READ;
          end else if (last_seq) begin
            state <= ST_OUT;
          end else begin
            seq <= seq + 1'b1;
          end
        end
        ST_READ: begin
          // read data is registered and arrives in the cycle after its address
          if (rd_cnt != '0) res_arg[2'(rd_cnt - 1'b1)] <= rd_ok ? rd_data : 8'h00;
          if (rd_cnt == RD_W'(N_OUT)) state <= ST_OUT;
          else rd_cnt <= rd_cnt + 1'b1;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'h0, res_arg[3], res_arg[2], res_arg[1], res_arg[0],
                         res_which, res_completed, res_consumed};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a completed result is always consumed
  a_done_eats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
    else $error("completed result not marked consumed");

  // a reported sequence index exists
  a_which_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> (int'(m_tdata[3:2]) < NUM_ACTIVE))
    else $error("completed sequence index out of range");

  // the argument read sweep never runs past the output slots
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (int'(rd_cnt) <= N_OUT))
    else $error("argument read count overrun");

  // a new item is never taken while one is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

endmodule
